### hw/rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg: shared types and constants for the rgb/cmyk converter
// channel width, full-scale value and the word that flows down the divider
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PROD_BITS    = 2 * CHANNEL_BITS;
  localparam int LANES        = 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PROD_BITS-1:0]    prod_t;

  localparam chan_t FULL = '1;
  localparam chan_t ONE  = chan_t'(1);
  localparam chan_t ZERO = '0;

  typedef enum logic {
    FUNC_RGB_TO_CMYK = 1'b0,
    FUNC_CMYK_TO_RGB = 1'b1
  } func_t;

  // one divider lane: remainder in hi, shifting dividend/quotient in lo
  typedef struct packed {
    chan_t hi;
    chan_t lo;
    chan_t dvs;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    chan_t             kout;
  } word_t;

endpackage

### hw/rtl/rgb_cmyk_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_cmyk_converter_top: pipelined rgb <-> cmyk pixel converter
// two front stages, then one stage per quotient bit of the long division
// throughput is one word per cycle; every stage holds its word under stall
// and refills any bubble, so a full pipe stalls only when the output does
// synchronous active-high rst clears all valid bits; payload is not reset
// ----------------------------------------------------------------------------
module rgb_cmyk_converter_top (
  input  logic            clk,
  input  logic            rst,
  // input word
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            func,
  input  rcc_pkg::chan_t  in_a,
  input  rcc_pkg::chan_t  in_b,
  input  rcc_pkg::chan_t  in_c,
  input  rcc_pkg::chan_t  in_d,
  // output word
  output logic            out_valid,
  input  logic            out_stall,
  output rcc_pkg::chan_t  out_a,
  output rcc_pkg::chan_t  out_b,
  output rcc_pkg::chan_t  out_c,
  output rcc_pkg::chan_t  out_d
);

  // chain of divider stages; index 0 is the front end output
  rcc_pkg::word_t  wd [0:rcc_pkg::CHANNEL_BITS];
  logic            vd [0:rcc_pkg::CHANNEL_BITS];
  logic            sd [0:rcc_pkg::CHANNEL_BITS];

  // front end: max(r,g,b), then dividend = product, divisor = max or full
  // for rgb->cmyk: (max - chan) * full / max, black pixel gives zero
  // for cmyk->rgb: (full - ink) * (full - k) / full
  rcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .func     (func),
    .in_a     (in_a),
    .in_b     (in_b),
    .in_c     (in_c),
    .in_d     (in_d),
    .dn_valid (vd[0]),
    .dn_stall (sd[0]),
    .dn_word  (wd[0])
  );

  // one quotient bit per stage; quotient never exceeds full scale,
  // so channel-width steps give the exact floor and no saturation is needed
  for (genvar g = 0; g < rcc_pkg::CHANNEL_BITS; g++) begin : g_div
    rcc_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vd[g]),
      .up_stall (sd[g]),
      .up_word  (wd[g]),
      .dn_valid (vd[g+1]),
      .dn_stall (sd[g+1]),
      .dn_word  (wd[g+1])
    );
  end

  // last divider stage is the output register
  assign sd[rcc_pkg::CHANNEL_BITS] = out_stall;
  assign out_valid = vd[rcc_pkg::CHANNEL_BITS];
  assign out_a     = wd[rcc_pkg::CHANNEL_BITS].lane[0].lo;
  assign out_b     = wd[rcc_pkg::CHANNEL_BITS].lane[1].lo;
  assign out_c     = wd[rcc_pkg::CHANNEL_BITS].lane[2].lo;
  assign out_d     = wd[rcc_pkg::CHANNEL_BITS].kout;

endmodule

### hw/rtl/rcc_front.sv
// ----------------------------------------------------------------------------
// rcc_front: max search and product stages
// stage 1 finds max(r,g,b); stage 2 forms the k output and each lane's dividend and divisor
// ----------------------------------------------------------------------------
module rcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_stall,
  input  logic                func,
  input  rcc_pkg::chan_t      in_a,
  input  rcc_pkg::chan_t      in_b,
  input  rcc_pkg::chan_t      in_c,
  input  rcc_pkg::chan_t      in_d,
  output logic                dn_valid,
  input  logic                dn_stall,
  output rcc_pkg::word_t      dn_word
);

  // stage 1 registers
  logic                                 v1;
  logic                                 func1;
  rcc_pkg::chan_t [rcc_pkg::LANES-1:0]  ch1;
  rcc_pkg::chan_t                       k1;
  rcc_pkg::chan_t                       mx1;
  rcc_pkg::chan_t                       mx_ab;
  rcc_pkg::chan_t                       mx_next;
  logic                                 stall1;
  logic                                 stall2;

  // stage 2 logic
  rcc_pkg::word_t                       word_next;
  rcc_pkg::prod_t                       px;
  rcc_pkg::prod_t                       py;
  rcc_pkg::prod_t                       prod;

  assign stall2   = dn_valid && dn_stall;
  assign stall1   = v1 && stall2;
  assign up_stall = stall1;

  always_comb begin
    mx_ab   = (in_b > in_a) ? in_b : in_a;
    mx_next = (in_c > mx_ab) ? in_c : mx_ab;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!stall1) begin
      v1 <= up_valid;
    end
    if (!stall1) begin
      func1  <= func;
      ch1[0] <= in_a;
      ch1[1] <= in_b;
      ch1[2] <= in_c;
      k1     <= in_d;
      mx1    <= mx_next;
    end
  end

  always_comb begin
    word_next = '0;
    px        = '0;
    py        = '0;
    prod      = '0;
    for (int i = 0; i < rcc_pkg::LANES; i++) begin
      if (func1 == rcc_pkg::FUNC_CMYK_TO_RGB) begin
        px = {rcc_pkg::ZERO, rcc_pkg::chan_t'(rcc_pkg::FULL - ch1[i])};
        py = {rcc_pkg::ZERO, rcc_pkg::chan_t'(rcc_pkg::FULL - k1)};
      end else begin
        px = {rcc_pkg::ZERO, rcc_pkg::chan_t'(mx1 - ch1[i])};
        py = {rcc_pkg::ZERO, rcc_pkg::FULL};
      end
      prod = rcc_pkg::prod_t'(px * py);
      word_next.lane[i].hi = prod[rcc_pkg::PROD_BITS-1:rcc_pkg::CHANNEL_BITS];
      word_next.lane[i].lo = prod[rcc_pkg::CHANNEL_BITS-1:0];
      if (func1 == rcc_pkg::FUNC_CMYK_TO_RGB) begin
        word_next.lane[i].dvs = rcc_pkg::FULL;
      end else if (mx1 == rcc_pkg::ZERO) begin
        // black pixel: dividend is zero, any nonzero divisor gives zero
        word_next.lane[i].dvs = rcc_pkg::ONE;
      end else begin
        word_next.lane[i].dvs = mx1;
      end
    end
    if (func1 == rcc_pkg::FUNC_CMYK_TO_RGB) begin
      word_next.kout = rcc_pkg::ZERO;
    end else begin
      word_next.kout = rcc_pkg::chan_t'(rcc_pkg::FULL - mx1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall2) begin
      dn_valid <= v1;
    end
    if (!stall2) begin
      dn_word <= word_next;
    end
  end

endmodule

### hw/rtl/rcc_div_stage.sv
// ----------------------------------------------------------------------------
// rcc_div_stage: one restoring division step on all three lanes
// shifts one dividend bit into the remainder and one quotient bit out
// ----------------------------------------------------------------------------
module rcc_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_stall,
  input  rcc_pkg::word_t  up_word,
  output logic            dn_valid,
  input  logic            dn_stall,
  output rcc_pkg::word_t  dn_word
);

  rcc_pkg::word_t                   word_next;
  logic [rcc_pkg::CHANNEL_BITS:0]   t;
  logic [rcc_pkg::CHANNEL_BITS:0]   dv;
  logic                             stall;

  assign stall    = dn_valid && dn_stall;
  assign up_stall = stall;

  always_comb begin
    word_next = up_word;
    t         = '0;
    dv        = '0;
    for (int i = 0; i < rcc_pkg::LANES; i++) begin
      t  = {up_word.lane[i].hi, up_word.lane[i].lo[rcc_pkg::CHANNEL_BITS-1]};
      dv = {1'b0, up_word.lane[i].dvs};
      word_next.lane[i].lo = {up_word.lane[i].lo[rcc_pkg::CHANNEL_BITS-2:0], 1'b0};
      if (t >= dv) begin
        word_next.lane[i].hi    = rcc_pkg::chan_t'(t - dv);
        word_next.lane[i].lo[0] = 1'b1;
      end else begin
        word_next.lane[i].hi = t[rcc_pkg::CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!stall) begin
      dn_valid <= up_valid;
    end
    if (!stall) begin
      dn_word <= word_next;
    end
  end

endmodule
